>>> hdl/ksq_pkg.sv
// ----------------------------------------------------------------------------
// ksq_pkg
// Shared constants, types and helpers for the keyword square transpose cipher.
// ----------------------------------------------------------------------------
package ksq_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
	localparam int IDX_W       = $clog2(CELLS);
	localparam int CNT_W       = $clog2(CELLS + 1);
	localparam int CHAR_W      = 8;
	localparam int OP_W        = 2;

	localparam logic [OP_W-1:0] OP_KEY = 2'd0;
	localparam logic [OP_W-1:0] OP_ENC = 2'd1;
	localparam logic [OP_W-1:0] OP_DEC = 2'd2;

	localparam logic [CHAR_W-1:0] FIRST_LETTER = 8'h41; // 'A'
	localparam logic [CHAR_W-1:0] LAST_LETTER  = 8'h59; // 'Y'
	localparam logic [CHAR_W-1:0] LOWER_A      = 8'h61; // 'a'
	localparam logic [CHAR_W-1:0] LOWER_Z      = 8'h7A; // 'z'
	localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

	// one RAM port group: write port plus read address
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	function automatic logic in_alphabet(input logic [CHAR_W-1:0] ch);
		return ch inside {[FIRST_LETTER:LAST_LETTER]};
	endfunction

	// cell row*SIDE+col -> cell col*SIDE+row
	function automatic logic [IDX_W-1:0] transpose_cell(input logic [IDX_W-1:0] pos);
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		row = '0;
		for (int r = 1; r < SQUARE_SIDE; r++) begin
			if (pos >= IDX_W'(r * SQUARE_SIDE)) begin
				row = IDX_W'(r);
			end
		end
		col = pos - IDX_W'(row * SQUARE_SIDE);
		return IDX_W'(col * SQUARE_SIDE + row);
	endfunction

endpackage

>>> hdl/ksq_ram.sv
// ----------------------------------------------------------------------------
// ksq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ksq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/ksq_ctrl.sv
// ----------------------------------------------------------------------------
// ksq_ctrl
// Sequencer: shared letter placement unit for keyword and fill, two-read
// lookup for text, and the output register.
// ----------------------------------------------------------------------------
module ksq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ksq_pkg::OP_W-1:0]     op,
	input  logic [ksq_pkg::CHAR_W-1:0]   in_char,
	input  logic                         last,
	input  logic                         in_valid,
	output logic                         in_stall,
	output logic [ksq_pkg::CHAR_W-1:0]   out_char,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ksq_pkg::ram_req_t            sq_req,
	output ksq_pkg::ram_req_t            pos_req,
	input  logic [ksq_pkg::IDX_W-1:0]    sq_rdata,
	input  logic [ksq_pkg::IDX_W-1:0]    pos_rdata
);
	import ksq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_KEY   = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_LOOK1 = 3'd3;
	localparam logic [2:0] S_LOOK2 = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]        state_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [CHAR_W-1:0] res_q;
	logic [IDX_W-1:0]  fill_idx_q;
	logic [CNT_W-1:0]  fill_count_q;
	logic [CELLS-1:0]  used_q;
	logic              ready_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_valid_q;

	logic              accept;
	logic [CHAR_W-1:0] key;
	logic              place_en;
	logic [IDX_W-1:0]  place_idx;
	logic              place_we;
	logic              out_free;
	logic [CHAR_W-1:0] char_off;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// encrypt folds lower case; decrypt does not
	always_comb begin
		key = in_char;
		if (op == OP_ENC && (in_char inside {[LOWER_A:LOWER_Z]})) begin
			key = in_char - CASE_OFFSET;
		end
	end

	// shared placement unit
	assign char_off  = char_q - FIRST_LETTER;
	assign place_idx = (state_q == S_FILL) ? fill_idx_q : char_off[IDX_W-1:0];
	assign place_en  = (state_q == S_FILL) || (state_q == S_KEY && in_alphabet(char_q));
	assign place_we  = place_en && (fill_count_q < CNT_W'(CELLS)) && !used_q[place_idx];

	always_comb begin
		logic [CHAR_W-1:0] key_off;
		key_off       = key - FIRST_LETTER;
		sq_req.we     = place_we;
		sq_req.waddr  = fill_count_q[IDX_W-1:0];
		sq_req.wdata  = place_idx;
		sq_req.raddr  = transpose_cell(pos_rdata);
		pos_req.we    = place_we;
		pos_req.waddr = place_idx;
		pos_req.wdata = fill_count_q[IDX_W-1:0];
		pos_req.raddr = key_off[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_idx_q   <= '0;
			fill_count_q <= '0;
			used_q       <= '0;
			ready_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// load a new beat, or drop the one just taken
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (place_we) begin
				used_q[place_idx] <= 1'b1;
				fill_count_q      <= fill_count_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							OP_KEY: begin
								if (!ready_q) begin
									state_q <= S_KEY;
								end
							end
							OP_ENC, OP_DEC: begin
								if (ready_q && in_alphabet(key)) begin
									state_q <= S_LOOK1;
								end else begin
									state_q <= S_OUT;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_KEY: begin
					fill_idx_q <= '0;
					state_q    <= last_q ? S_FILL : S_IDLE;
				end
				S_FILL: begin
					fill_idx_q <= fill_idx_q + IDX_W'(1);
					if (fill_idx_q == IDX_W'(CELLS - 1)) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LOOK1: state_q <= S_LOOK2;
				S_LOOK2: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= in_char;
			last_q <= last;
			res_q  <= in_char;
		end
		if (state_q == S_LOOK2) begin
			res_q <= FIRST_LETTER + CHAR_W'(sq_rdata);
		end
		if (state_q == S_OUT && out_free) begin
			out_char_q <= res_q;
		end
	end

	assign out_char  = out_char_q;
	assign out_valid = out_valid_q;

endmodule

>>> hdl/keyword_square_transpose_cipher_top.sv
// ----------------------------------------------------------------------------
// keyword_square_transpose_cipher_top
// 5x5 keyword letter square with row/column transpose substitution.
// ----------------------------------------------------------------------------
// Keyword beats (op 0) place letters A..Y into the square in arrival order,
// skipping repeats and anything outside A..Y; the beat marked last then fills
// the remaining cells with unused letters alphabetically and the square goes
// ready. Keyword beats after the square is ready, and op 3 beats, are taken
// and dropped with no output; any other keyword beat, placed or skipped, goes
// through the placement state, and the last one adds a fill walk. Text
// beats (op 1 encrypt, which folds lower case, op 2 decrypt) each produce one
// output beat: a letter at row r, column c becomes the letter at row c,
// column r; any other byte, and all text before the square is ready, passes
// through. A substituted letter goes through two dependent reads (of the
// letter-to-cell and cell-to-letter RAMs), then the output register; a
// passed-through byte goes straight to the output register. One beat is in
// flight at a time: in_stall is high while the sequencer works, and a
// finished result sits in the output register so the next input beat can be
// taken while it waits. The square RAMs come up undefined and need no
// clearing, since lookups only start once every cell is written.
// ----------------------------------------------------------------------------
module keyword_square_transpose_cipher_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ksq_pkg::OP_W-1:0]   op,
	input  logic [ksq_pkg::CHAR_W-1:0] in_char,
	input  logic                       last,
	input  logic                       in_valid,
	output logic                       in_stall,
	output logic [ksq_pkg::CHAR_W-1:0] out_char,
	output logic                       out_valid,
	input  logic                       out_stall
);
	import ksq_pkg::*;

	ram_req_t         sq_req;
	ram_req_t         pos_req;
	logic [IDX_W-1:0] sq_rdata;
	logic [IDX_W-1:0] pos_rdata;

	// sequencer, placement unit, output register
	ksq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_char   (in_char),
		.last      (last),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_char  (out_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sq_req    (sq_req),
		.pos_req   (pos_req),
		.sq_rdata  (sq_rdata),
		.pos_rdata (pos_rdata)
	);

	// cell -> letter index
	ksq_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_square_ram (
		.clk   (clk),
		.we    (sq_req.we),
		.waddr (sq_req.waddr),
		.wdata (sq_req.wdata),
		.raddr (sq_req.raddr),
		.rdata (sq_rdata)
	);

	// letter index -> cell
	ksq_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_position_ram (
		.clk   (clk),
		.we    (pos_req.we),
		.waddr (pos_req.waddr),
		.wdata (pos_req.wdata),
		.raddr (pos_req.raddr),
		.rdata (pos_rdata)
	);

endmodule
